[design/ste_pkg.sv]
`default_nettype none
package ste_pkg;

  typedef struct packed {
    logic [3:0] opcode;
    logic [3:0] qubit_a;
    logic [3:0] qubit_b;
  } ste_in_t;

  typedef struct packed {
    logic outcome;
    logic deterministic;
    logic error;
  } ste_out_t;

  localparam logic [3:0] OpReset = 4'd0;
  localparam logic [3:0] OpH     = 4'd1;
  localparam logic [3:0] OpS     = 4'd2;
  localparam logic [3:0] OpSdg   = 4'd3;
  localparam logic [3:0] OpX     = 4'd4;
  localparam logic [3:0] OpY     = 4'd5;
  localparam logic [3:0] OpZ     = 4'd6;
  localparam logic [3:0] OpCnot  = 4'd7;
  localparam logic [3:0] OpCz    = 4'd8;
  localparam logic [3:0] OpSwap  = 4'd9;
  localparam logic [3:0] OpMeas  = 4'd10;
  localparam logic [3:0] OpQuery = 4'd11;

  localparam int unsigned CfgQubits = 0;
  localparam int unsigned CfgSeed   = 1;

  // Phase exponent (mod 4) of P1*P2 for one qubit.
  function automatic logic [1:0] gphase(input logic x1, input logic z1,
                                        input logic x2, input logic z2);
    logic [1:0] g;
    begin
      g = 2'd0;
      if (x1 && z1) begin
        g = 2'({1'b0, z2} - {1'b0, x2});
      end else if (x1) begin
        if (z2) g = x2 ? 2'd1 : 2'd3;
      end else if (z1) begin
        if (x2) g = z2 ? 2'd3 : 2'd1;
      end
      return g;
    end
  endfunction

  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] t;
    begin
      t = s ^ (s << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
    end
  endfunction

endpackage
`default_nettype wire

[design/stabilizer_tableau_engine_unit.sv]
`default_nettype none
// Channel  | signals                        | transfer
// cmd in   | start_i, busy_o, cmd_i         | start_i & !busy_o
// result   | done_o, res_o                  | done_o (one cycle, no stall)
// config   | cfg_we_i, cfg_idx_i, cfg_data_i | cfg_we_i
//
// Rows live in one synchronous RAM (2*MAX_QUBITS entries, registered read).
// Rows are swept one at a time: each is read, then modified and written back.
// Gates: one pass over all 2n rows; Sdg, CZ and SWAP take three passes, and
// a done state ends the command. Measure: a pivot scan over the stabilizer
// rows, then a rowsum sweep that multiplies rows by the source row, adding
// up the phase qubit by qubit.
// Reset (tableau to identity, opcode or qubits_in_use write) clears all
// 2*MAX_QUBITS rows. After rst_ni the block runs this clear before taking
// commands. The receiver cannot stall; done_o pulses once per command.
module stabilizer_tableau_engine_unit #(
  parameter int unsigned MAX_QUBITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output      logic            busy_o,
  input  wire ste_pkg::ste_in_t cmd_i,
  output      logic            done_o,
  output      ste_pkg::ste_out_t res_o,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [31:0]     cfg_data_i
);
  import ste_pkg::*;

  localparam int unsigned NR = 2 * MAX_QUBITS;
  localparam int unsigned RW = $clog2(NR);
  localparam int unsigned QW = $clog2(MAX_QUBITS + 1);
  localparam int unsigned CW = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
  localparam int unsigned PW = 1 + MAX_QUBITS + MAX_QUBITS;

  // state codes
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StClr   = 4'd1;
  localparam logic [3:0] StGRd   = 4'd2;  // gate sweep: issue read
  localparam logic [3:0] StGWr   = 4'd3;  // gate sweep: modify, write
  localparam logic [3:0] StPvt   = 4'd4;  // pivot scan
  localparam logic [3:0] StPRd   = 4'd5;  // load pivot/source row
  localparam logic [3:0] StPLd   = 4'd6;
  localparam logic [3:0] StMRd   = 4'd7;  // rowsum sweep: read target
  localparam logic [3:0] StMMul  = 4'd8;  // phase accumulate over qubits
  localparam logic [3:0] StMWr   = 4'd9;
  localparam logic [3:0] StFin   = 4'd10; // finish random measurement
  localparam logic [3:0] StDone  = 4'd11;

  // row layout {r, z, x}
  logic [PW-1:0] mem_q [NR];
  logic [PW-1:0] rd_q;
  logic          we;
  logic [RW-1:0] waddr, raddr;
  logic [PW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  logic [3:0]           st_q, st_d;
  logic [QW-1:0]        n_q;
  logic [31:0]          seed_q, rng_q, rng_d;
  logic [3:0]           op_q;
  logic [CW-1:0]        a_q, b_q;
  logic [RW:0]          i_q, i_d;        // row counter
  logic [RW-1:0]        piv_q, piv_d;
  logic                 pf_q, pf_d;      // pivot found
  logic [MAX_QUBITS-1:0] sx_q, sz_q, sx_d, sz_d;  // source (pivot) row
  logic                 sr_q, sr_d;
  logic [MAX_QUBITS-1:0] hx_q, hz_q, hx_d, hz_d;  // accumulator / target
  logic                 hr_q, hr_d;
  logic [1:0]           ph_q, ph_d;
  logic [CW:0]          j_q, j_d;
  logic [2:0]           sw_q, sw_d;      // sub-pass for compound gates
  logic                 busy_q;
  ste_out_t             res_q, res_d;
  logic                 done_q, done_d;
  logic                 done_pending_q;

  logic [RW:0] nrows;
  assign nrows = (RW+1)'({n_q, 1'b0});

  logic [QW-1:0] n_cfg;
  always_comb begin
    if (cfg_data_i[4:0] == 5'd0) n_cfg = QW'(1);
    else if ({27'd0, cfg_data_i[4:0]} > MAX_QUBITS) n_cfg = QW'(MAX_QUBITS);
    else n_cfg = QW'(cfg_data_i[4:0]);
  end

  // command decode
  logic one_q, two_q, err_c;
  always_comb begin
    two_q = (cmd_i.opcode == OpCnot) || (cmd_i.opcode == OpCz) ||
            (cmd_i.opcode == OpSwap);
    one_q = (cmd_i.opcode >= OpH && cmd_i.opcode <= OpZ) ||
            (cmd_i.opcode == OpMeas) || (cmd_i.opcode == OpQuery);
    err_c = ((one_q || two_q) && ({1'b0, cmd_i.qubit_a} >= 5'(n_q))) ||
            (two_q && ({1'b0, cmd_i.qubit_b} >= 5'(n_q)));
  end

  // identity row for index i
  function automatic logic [PW-1:0] id_row(input logic [RW:0] i,
                                           input logic [QW-1:0] n);
    logic [MAX_QUBITS-1:0] x, z;
    begin
      x = '0; z = '0;
      if (i < (RW+1)'(n)) x[i[CW-1:0]] = 1'b1;
      else if (i < (RW+1)'({n, 1'b0})) z[CW'(i - (RW+1)'(n))] = 1'b1;
      return {1'b0, z, x};
    end
  endfunction

  // single-qubit / two-qubit primitive on one row; kind selects op
  localparam logic [2:0] PH = 3'd0, PS = 3'd1, PCX = 3'd2, PX = 3'd3,
                         PY = 3'd4, PZ = 3'd5;
  function automatic logic [PW-1:0] prim(input logic [PW-1:0] row,
      input logic [2:0] k, input logic [CW-1:0] c, input logic [CW-1:0] t);
    logic [MAX_QUBITS-1:0] x, z;
    logic r, xc, zc, xt, zt;
    begin
      x = row[MAX_QUBITS-1:0];
      z = row[2*MAX_QUBITS-1:MAX_QUBITS];
      r = row[PW-1];
      xc = x[c]; zc = z[c]; xt = x[t]; zt = z[t];
      unique case (k)
        PH: begin r = r ^ (xc & zc); x[c] = zc; z[c] = xc; end
        PS: begin r = r ^ (xc & zc); z[c] = zc ^ xc; end
        PCX: begin
          r = r ^ (xc & zt & ~(xt ^ zc));
          x[t] = xt ^ xc; z[c] = zc ^ zt;
        end
        PX: r = r ^ zc;
        PY: r = r ^ zc ^ xc;
        PZ: r = r ^ xc;
        default: ;
      endcase
      return {r, z, x};
    end
  endfunction

  // sub-pass plan: number of passes and the primitive for pass sw
  logic [2:0] npass;
  logic [2:0] pk;
  logic [CW-1:0] pc, pt;
  always_comb begin
    npass = 3'd1; pk = PH; pc = a_q; pt = b_q;
    unique case (op_q)
      OpH:   pk = PH;
      OpS:   pk = PS;
      OpSdg: begin npass = 3'd3; pk = PS; end
      OpX:   pk = PX;
      OpY:   pk = PY;
      OpZ:   pk = PZ;
      OpCnot: pk = PCX;
      OpCz: begin
        npass = 3'd3;
        if (sw_q == 3'd1) pk = PCX; else begin pk = PH; pc = b_q; end
      end
      OpSwap: begin
        npass = 3'd3; pk = PCX;
        if (sw_q == 3'd1) begin pc = b_q; pt = a_q; end
      end
      default: ;
    endcase
  end

  logic [RW-1:0] irow;
  assign irow = i_q[RW-1:0];

  always_comb begin
    st_d = st_q; i_d = i_q; piv_d = piv_q; pf_d = pf_q;
    sx_d = sx_q; sz_d = sz_q; sr_d = sr_q;
    hx_d = hx_q; hz_d = hz_q; hr_d = hr_q; ph_d = ph_q; j_d = j_q;
    sw_d = sw_q; rng_d = rng_q; res_d = res_q; done_d = 1'b0;
    we = 1'b0; waddr = irow; wdata = '0; raddr = irow;
    unique case (st_q)
      StIdle: ;
      StClr: begin
        we = 1'b1; wdata = id_row(i_q, n_q);
        if (i_q == (RW+1)'(NR - 1)) st_d = StDone;
        else i_d = i_q + 1'b1;
      end
      StGRd: st_d = StGWr;
      StGWr: begin
        we = 1'b1; wdata = prim(rd_q, pk, pc, pt);
        if (i_q + 1'b1 == nrows) begin
          i_d = '0;
          if (sw_q + 3'd1 == npass) st_d = StDone;
          else begin sw_d = sw_q + 3'd1; st_d = StGRd; end
        end else begin
          i_d = i_q + 1'b1; st_d = StGRd;
        end
        raddr = RW'(i_d);
      end
      StPvt: begin
        // rd_q holds row i_q-1 once i_q > n
        if (i_q > (RW+1)'(n_q) && rd_q[a_q] && !pf_q) begin
          pf_d = 1'b1; piv_d = RW'(i_q - 1'b1);
        end
        if (i_q == nrows) begin
          st_d = StPRd; i_d = '0;
          res_d.deterministic = ~pf_d;
          if (op_q == OpQuery) st_d = StDone;
          else if (!pf_d) begin
            hx_d = '0; hz_d = '0; hr_d = 1'b0;
            st_d = StMRd;
          end
          raddr = piv_d;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      StPRd: begin raddr = piv_q; st_d = StPLd; end  // hold pivot read
      StPLd: begin
        sx_d = rd_q[MAX_QUBITS-1:0];
        sz_d = rd_q[2*MAX_QUBITS-1:MAX_QUBITS];
        sr_d = rd_q[PW-1];
        i_d = '0; raddr = '0; st_d = StMRd;
      end
      StMRd: begin
        // deterministic: scan destab row i (need x bit), source stab n+i
        // random: target row i, source = pivot
        if (pf_q) begin
          if (i_q == nrows) st_d = StFin;
          else begin raddr = irow; st_d = StMMul; j_d = '0; sw_d = 3'd0; end
        end else begin
          if (i_q == (RW+1)'(n_q)) begin
            res_d.outcome = hr_q; st_d = StDone;
          end else begin
            raddr = irow; st_d = StMMul; j_d = '0; sw_d = 3'd0;
          end
        end
      end
      StMMul: begin
        // sw 0: data of read arrives
        if (sw_q == 3'd0) begin
          if (!rd_q[a_q] || (pf_q && irow == piv_q)) begin
            i_d = i_q + 1'b1; st_d = StMRd;
          end else if (pf_q) begin
            hx_d = rd_q[MAX_QUBITS-1:0];
            hz_d = rd_q[2*MAX_QUBITS-1:MAX_QUBITS];
            hr_d = rd_q[PW-1];
            ph_d = {hr_d, 1'b0} + {sr_q, 1'b0};
            sw_d = 3'd2;
          end else begin
            raddr = RW'(i_q + (RW+1)'(n_q)); sw_d = 3'd1;
          end
        end else if (sw_q == 3'd1) begin
          sx_d = rd_q[MAX_QUBITS-1:0];
          sz_d = rd_q[2*MAX_QUBITS-1:MAX_QUBITS];
          sr_d = rd_q[PW-1];
          ph_d = {hr_q, 1'b0} + {sr_d, 1'b0};
          sw_d = 3'd3;
        end else begin
          ph_d = ph_q + gphase(sx_q[j_q[CW-1:0]], sz_q[j_q[CW-1:0]],
                               hx_q[j_q[CW-1:0]], hz_q[j_q[CW-1:0]]);
          if (j_q + 1'b1 == (CW+1)'(n_q)) begin
            hr_d = ph_d[1]; hx_d = hx_q ^ sx_q; hz_d = hz_q ^ sz_q;
            if (sw_q == 3'd2) st_d = StMWr;
            else begin i_d = i_q + 1'b1; st_d = StMRd; end
          end else j_d = j_q + 1'b1;
        end
      end
      StMWr: begin
        we = 1'b1; wdata = {hr_q, hz_q, hx_q};
        i_d = i_q + 1'b1; st_d = StMRd;
      end
      StFin: begin
        // copy pivot to destab p-n, then write Z_a with random phase
        if (sw_q != 3'd7) begin
          we = 1'b1; waddr = RW'(piv_q - RW'(n_q));
          wdata = {sr_q, sz_q, sx_q}; sw_d = 3'd7;
          rng_d = xorshift(rng_q);
        end else begin
          we = 1'b1; waddr = piv_q;
          wdata = '0; wdata[MAX_QUBITS + a_q] = 1'b1; wdata[PW-1] = rng_q[31];
          res_d.outcome = rng_q[31]; st_d = StDone;
        end
      end
      StDone: begin done_d = 1'b1; st_d = StIdle; end
      default: st_d = StIdle;
    endcase

    if (st_q == StIdle && start_i) begin
      res_d = '0; i_d = '0; sw_d = '0; pf_d = 1'b0;
      if (err_c) begin res_d.error = 1'b1; st_d = StDone; end
      else begin
        unique case (cmd_i.opcode)
          OpReset: st_d = StClr;
          OpH, OpS, OpSdg, OpX, OpY, OpZ: st_d = StGRd;
          OpCnot, OpCz, OpSwap:
            st_d = (cmd_i.qubit_a == cmd_i.qubit_b) ? StDone : StGRd;
          OpMeas, OpQuery: st_d = StPvt;
          default: st_d = StDone;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; i_q <= '0; n_q <= QW'(MAX_QUBITS);
      seed_q <= 32'd1; rng_q <= 32'd1; done_q <= 1'b0; res_q <= '0;
      busy_q <= 1'b1; sw_q <= '0; pf_q <= 1'b0;
      op_q <= OpReset; a_q <= '0; b_q <= '0;
    end else begin
      st_q <= st_d; i_q <= i_d; rng_q <= rng_d; done_q <= done_d;
      res_q <= res_d; sw_q <= sw_d; pf_q <= pf_d;
      busy_q <= (st_d != StIdle);
      if (st_q == StIdle && start_i) begin
        op_q <= cmd_i.opcode;
        a_q <= CW'(cmd_i.qubit_a); b_q <= CW'(cmd_i.qubit_b);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'(CfgSeed)) begin
          seed_q <= cfg_data_i;
          rng_q <= (cfg_data_i == 32'd0) ? 32'd1 : cfg_data_i;
        end else begin
          n_q <= n_cfg; st_q <= StClr; i_q <= '0; busy_q <= 1'b1;
        end
      end
      if (st_q == StClr && st_d == StDone && !(cfg_we_i && cfg_idx_i == 1'(CfgQubits)))
        begin
        st_q <= StIdle; busy_q <= 1'b0;  // silent after config/reset clear
        if (op_q == OpReset && done_pending_q) begin
          st_q <= StDone; busy_q <= 1'b1;
        end
      end
    end
  end

  // clear after reset/config produces no result; opcode reset does
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_pending_q <= 1'b0;
    else if (cfg_we_i && cfg_idx_i == 1'(CfgQubits)) done_pending_q <= 1'b0;
    else if (st_q == StIdle && start_i) done_pending_q <= 1'b1;
    else if (st_q == StDone) done_pending_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    piv_q <= piv_d; sx_q <= sx_d; sz_q <= sz_d; sr_q <= sr_d;
    hx_q <= hx_d; hz_q <= hz_d; hr_q <= hr_d; ph_q <= ph_d; j_q <= j_d;
  end

  logic unused_seed;
  assign unused_seed = ^seed_q;

  assign busy_o = busy_q | unused_seed & 1'b0;
  assign done_o = done_q;
  assign res_o  = res_q;
endmodule
`default_nettype wire
